// ----- hdl/tdr_pkg.sv -----
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared widths, defaults and command codes for the triangle depth rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package tdr_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // rounded pixel coordinates and their differences
  localparam int CW = 14;
  // edge values, area
  localparam int EW = 28;
  // multiplier second operand (signed, holds a 16-bit unsigned depth)
  localparam int BW = 17;
  localparam int PW = EW + BW;
  // accumulator / division remainder
  localparam int AW = PW + 1;

  localparam int DW = 16;
  localparam int NW = 19;
  localparam logic [NW-1:0] COUNT_MAX = {NW{1'b1}};

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

endpackage

`default_nettype wire

// ----- hdl/triangle_depth_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer_unit
// Draws one triangle per draw transaction into an on-chip depth store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command: draw, read or
//   write a depth entry. in_stall_o stays high from acceptance until the
//   result transaction has left on the output channel (out_valid_o /
//   out_stall_i); one command is in flight at a time.
//   Configuration writes (cfg_valid_i / cfg_ready_o) set the screen size and
//   are taken in any cycle; issue them only while the block is idle.
// Cost:
//   A draw runs a setup phase, then visits each pixel of the clipped
//   bounding box in turn, and adds a depth multiply and divide for each
//   covered pixel. The single shared multiplier (area, edge set-up, depth
//   numerator) and the one-bit-per-cycle restoring divider for the depth
//   set this cost.
// Reset:
//   control state clears and the screen size returns to 512 by 512. The
//   depth store is not cleared; software writes it before use.
// Stall:
//   a result waits in its output registers, unchanged, while out_stall_i is
//   high.
`default_nettype none

module triangle_depth_rasterizer_unit #(
  parameter int MAX_WIDTH  = tdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tdr_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              opcode_i,
  input  wire logic signed [15:0]      vert0_x_i,
  input  wire logic signed [15:0]      vert0_y_i,
  input  wire logic [15:0]             vert0_z_i,
  input  wire logic signed [15:0]      vert1_x_i,
  input  wire logic signed [15:0]      vert1_y_i,
  input  wire logic [15:0]             vert1_z_i,
  input  wire logic signed [15:0]      vert2_x_i,
  input  wire logic signed [15:0]      vert2_y_i,
  input  wire logic [15:0]             vert2_z_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [tdr_pkg::DW-1:0]       depth_value_o,
  output logic [tdr_pkg::NW-1:0]       pixels_covered_o,
  output logic [tdr_pkg::NW-1:0]       pixels_updated_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [9:0]              cfg_data_i
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MW    = $clog2(DEPTH);
  localparam int CW    = tdr_pkg::CW;
  localparam int EW    = tdr_pkg::EW;
  localparam int BW    = tdr_pkg::BW;
  localparam int PW    = tdr_pkg::PW;
  localparam int AW    = tdr_pkg::AW;
  localparam int DW    = tdr_pkg::DW;
  localparam int NW    = tdr_pkg::NW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_BOX, S_AREA, S_EDGE, S_ROW, S_PIX, S_MUL, S_DIV, S_WR,
    S_RD, S_RESP
  } state_e;

  state_e state_q;
  logic [4:0] k_q;

  logic [1:0]        op_q;
  logic signed [15:0] vx_q [3];
  logic signed [15:0] vy_q [3];
  logic [15:0]       vz_q [3];
  logic signed [CW-1:0] cx_q [3];
  logic signed [CW-1:0] cy_q [3];
  logic signed [CW-1:0] dx_q [3];
  logic signed [CW-1:0] dy_q [3];
  logic [2:0]        tie_q;
  logic signed [CW-1:0] minx_q, maxx_q, miny_q, maxy_q, x_q, y_q;
  logic signed [EW-1:0] area_q;
  logic signed [EW-1:0] row_e_q [3];
  logic signed [EW-1:0] cur_e_q [3];
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [AW-1:0]     rem_q, div_q;
  logic [DW-1:0]     quo_q;
  logic [MW-1:0]     addr_q, row_base_q;
  logic [9:0]        scr_w_q, scr_h_q;
  logic [DW-1:0]     depth_q;
  logic [NW-1:0]     cov_q, upd_q;

  logic [DW-1:0]     mem_q [DEPTH];
  logic [DW-1:0]     rd_q;
  logic              mem_we;
  logic [MW-1:0]     mem_waddr;
  logic [DW-1:0]     mem_wdata;

  function automatic logic signed [CW-1:0] round_coord(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v ^ 16'h8000} + 17'd8;
    return $signed({1'b0, t[16:4]}) - CW'(2048);
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // ---- combinational helpers ----
  logic signed [CW-1:0] dxc [3];
  logic signed [CW-1:0] dyc [3];
  logic signed [CW-1:0] wlim, hlim, bminx, bmaxx, bminy, bmaxy;
  logic                 rw_ok;
  logic [MW-1:0]        rw_addr;
  logic signed [EW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic [2:0]           e_in;
  logic                 covered;
  logic signed [AW-1:0] acc_sub;
  logic                 last_x, last_y;

  always_comb begin
    dxc[0] = cx_q[0] - cx_q[1];
    dxc[1] = cx_q[1] - cx_q[2];
    dxc[2] = cx_q[2] - cx_q[0];
    dyc[0] = cy_q[0] - cy_q[1];
    dyc[1] = cy_q[1] - cy_q[2];
    dyc[2] = cy_q[2] - cy_q[0];
    wlim = ({4'd0, scr_w_q} < CW'(MAX_WIDTH))  ? $signed({4'd0, scr_w_q}) : CW'(MAX_WIDTH);
    hlim = ({4'd0, scr_h_q} < CW'(MAX_HEIGHT)) ? $signed({4'd0, scr_h_q}) : CW'(MAX_HEIGHT);
    bminx = smax(smin(smin(cx_q[0], cx_q[1]), cx_q[2]), '0);
    bminy = smax(smin(smin(cy_q[0], cy_q[1]), cy_q[2]), '0);
    bmaxx = smin(smax(smax(cx_q[0], cx_q[1]), cx_q[2]), wlim - CW'(1));
    bmaxy = smin(smax(smax(cy_q[0], cy_q[1]), cy_q[2]), hlim - CW'(1));

    rw_ok = !vx_q[0][15] && !vy_q[0][15] &&
            (vx_q[0][14:0] < 15'(MAX_WIDTH)) && (vy_q[0][14:0] < 15'(MAX_HEIGHT));
    rw_addr = MW'(MW'(vy_q[0][14:0]) * MW'(MAX_WIDTH)) + MW'(vx_q[0][14:0]);

    for (int i = 0; i < 3; i++) begin
      e_in[i] = (cur_e_q[i] > 0) || ((cur_e_q[i] == 0) && !tie_q[i]);
    end
    covered = &e_in;
    last_x  = (x_q == maxx_q);
    last_y  = (y_q == maxy_q);
    acc_sub = acc_q - AW'(prod_q);

    // shared multiplier operand selection
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_AREA: begin
        if (k_q[0]) begin
          mul_a = EW'(dy_q[0]);
          mul_b = BW'(dx_q[1]);
        end else begin
          mul_a = EW'(dx_q[0]);
          mul_b = BW'(dy_q[1]);
        end
      end
      S_EDGE: begin
        if (k_q[0]) begin
          mul_a = EW'(miny_q - cy_q[k_q[2:1]]);
          mul_b = BW'(dx_q[k_q[2:1]]);
        end else begin
          mul_a = EW'(minx_q - cx_q[k_q[2:1]]);
          mul_b = BW'(dy_q[k_q[2:1]]);
        end
      end
      S_MUL: begin
        case (k_q[1:0])
          2'd0:    begin mul_a = cur_e_q[0]; mul_b = $signed({1'b0, vz_q[2]}); end
          2'd1:    begin mul_a = cur_e_q[1]; mul_b = $signed({1'b0, vz_q[0]}); end
          default: begin mul_a = cur_e_q[2]; mul_b = $signed({1'b0, vz_q[1]}); end
        endcase
      end
      default: ;
    endcase

    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = quo_q;
    if (state_q == S_DEC && op_q == tdr_pkg::OP_WRITE && rw_ok) begin
      mem_we    = 1'b1;
      mem_waddr = rw_addr;
      mem_wdata = vz_q[0];
    end else if (state_q == S_WR && quo_q < rd_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q   <= mem_q[addr_q];
    prod_q <= mul_a * mul_b;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cfg_ready_o = 1'b1;
  assign depth_value_o    = depth_q;
  assign pixels_covered_o = cov_q;
  assign pixels_updated_o = upd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      scr_w_q <= 10'd512;
      scr_h_q <= 10'd512;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == tdr_pkg::REG_WIDTH)  scr_w_q <= cfg_data_i;
        if (cfg_index_i == tdr_pkg::REG_HEIGHT) scr_h_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q  <= opcode_i;
            vx_q  <= '{vert0_x_i, vert1_x_i, vert2_x_i};
            vy_q  <= '{vert0_y_i, vert1_y_i, vert2_y_i};
            vz_q  <= '{vert0_z_i, vert1_z_i, vert2_z_i};
            depth_q <= '0;
            cov_q   <= '0;
            upd_q   <= '0;
            k_q     <= '0;
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          for (int i = 0; i < 3; i++) begin
            cx_q[i] <= round_coord(vx_q[i]);
            cy_q[i] <= round_coord(vy_q[i]);
          end
          addr_q <= rw_addr;
          case (op_q)
            tdr_pkg::OP_DRAW: state_q <= S_BOX;
            tdr_pkg::OP_READ: state_q <= rw_ok ? S_RD : S_RESP;
            default:          state_q <= S_RESP;
          endcase
        end
        S_RD: begin
          // entry address registered, read data is registered in rd_q the cycle after
          k_q <= k_q + 5'd1;
          if (k_q == 5'd1) begin
            depth_q <= rd_q;
            state_q <= S_RESP;
          end
        end
        S_BOX: begin
          dx_q   <= dxc;
          dy_q   <= dyc;
          tie_q[0] <= (dyc[0] == 0 && vy_q[2] > vy_q[1]) || dyc[0] < 0;
          tie_q[1] <= (dyc[1] == 0 && vy_q[0] > vy_q[2]) || dyc[1] < 0;
          tie_q[2] <= (dyc[2] == 0 && vy_q[1] > vy_q[0]) || dyc[2] < 0;
          minx_q <= bminx;
          maxx_q <= bmaxx;
          miny_q <= bminy;
          maxy_q <= bmaxy;
          k_q    <= '0;
          state_q <= S_AREA;
        end
        S_AREA: begin
          k_q <= k_q + 5'd1;
          if (k_q == 5'd0) begin
            row_base_q <= MW'(MW'(miny_q) * MW'(MAX_WIDTH));
          end
          if (k_q == 5'd1) begin
            acc_q <= AW'(prod_q);
          end
          if (k_q == 5'd2) begin
            area_q <= EW'(acc_sub);
            k_q    <= '0;
            if (acc_sub <= 0 || minx_q > maxx_q || miny_q > maxy_q) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          k_q <= k_q + 5'd1;
          if (k_q != 5'd0) begin
            if (k_q[0]) begin
              acc_q <= AW'(prod_q);
            end else begin
              row_e_q[k_q[2:1] - 2'd1] <= EW'(acc_sub);
            end
          end
          if (k_q == 5'd6) begin
            state_q <= S_ROW;
          end
        end
        S_ROW: begin
          cur_e_q <= row_e_q;
          x_q     <= minx_q;
          y_q     <= miny_q;
          addr_q  <= row_base_q + MW'(minx_q);
          state_q <= S_PIX;
        end
        S_PIX, S_WR: begin
          if (state_q == S_PIX && covered) begin
            if (cov_q != tdr_pkg::COUNT_MAX) cov_q <= cov_q + NW'(1);
            k_q     <= '0;
            state_q <= S_MUL;
          end else begin
            if (state_q == S_WR && mem_we && upd_q != tdr_pkg::COUNT_MAX) begin
              upd_q <= upd_q + NW'(1);
            end
            state_q <= S_PIX;
            if (!last_x) begin
              x_q    <= x_q + CW'(1);
              addr_q <= addr_q + MW'(1);
              for (int i = 0; i < 3; i++) cur_e_q[i] <= cur_e_q[i] + EW'(dy_q[i]);
            end else if (last_y) begin
              state_q <= S_RESP;
            end else begin
              x_q        <= minx_q;
              y_q        <= y_q + CW'(1);
              row_base_q <= row_base_q + MW'(MAX_WIDTH);
              addr_q     <= row_base_q + MW'(MAX_WIDTH) + MW'(minx_q);
              for (int i = 0; i < 3; i++) begin
                row_e_q[i] <= row_e_q[i] - EW'(dx_q[i]);
                cur_e_q[i] <= row_e_q[i] - EW'(dx_q[i]);
              end
            end
          end
        end
        S_MUL: begin
          k_q <= k_q + 5'd1;
          if (k_q == 5'd1) acc_q <= AW'(prod_q);
          if (k_q == 5'd2) acc_q <= acc_q + AW'(prod_q);
          if (k_q == 5'd3) begin
            // weights sum to the area, so the quotient fits in 16 bits
            rem_q   <= acc_q + AW'(prod_q);
            div_q   <= AW'(area_q) << (DW - 1);
            k_q     <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          k_q <= k_q + 5'd1;
          div_q <= div_q >> 1;
          if (rem_q >= div_q) begin
            rem_q <= rem_q - div_q;
            quo_q <= {quo_q[DW-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[DW-2:0], 1'b0};
          end
          if (k_q == 5'(DW - 1)) state_q <= S_WR;
        end
        S_RESP: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_take_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_upd_le_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixels_updated_o <= pixels_covered_o))
    else $error("more pixels updated than covered");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pixels_covered_o)
      && $stable(depth_value_o))) else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
